### rtl/stcp_pkg.sv
// ----------------------------------------------------------------------------
// stcp_pkg
// Shared types, constants and keyword tables of the serial text command parser.
// ----------------------------------------------------------------------------
package stcp_pkg;

   localparam int MAX_FRAME_BYTES    = 19;
   localparam int MAX_PARAM_CHARS    = 17;
   localparam int MAX_ADDRESS_DIGITS = 3;
   localparam int MIN_FRAME_BYTES    = 6;
   localparam int KW_COUNT           = 6;
   localparam int KW_MAX_LEN         = 9;

   localparam int COUNT_W = 5;
   localparam int POS_W   = 5;
   localparam int ADDR_W  = 10;
   localparam int LIMIT_W = 16;
   localparam int CMD_W   = 3;

   localparam logic [ADDR_W-1:0]  ADDRESS_CEIL = ADDR_W'(999);
   localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = LIMIT_W'(20000);

   // kind of an input item
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_T     = 8'h54;

   typedef enum logic [1:0] {
      PH_VERB  = 2'd0,
      PH_PARAM = 2'd1,
      PH_ADDR  = 2'd2,
      PH_VALUE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      VERB_NONE = 2'd0,
      VERB_SET  = 2'd1,
      VERB_GET  = 2'd2
   } verb_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE      = 3'd0,
      CMD_RESET     = 3'd1,
      CMD_COILS     = 3'd2,
      CMD_TEMP      = 3'd3,
      CMD_BPM       = 3'd4,
      CMD_ALL       = 3'd5,
      CMD_INPUTS    = 3'd6
   } command_type;

   // keyword bit positions in the alive mask
   localparam int KW_RESET     = 0;
   localparam int KW_COILS     = 1;
   localparam int KW_TEMP      = 2;
   localparam int KW_BPM       = 3;
   localparam int KW_ALL       = 4;
   localparam int KW_INPUTS    = 5;

   typedef logic [0:KW_MAX_LEN-1][7:0] kw_text_type;

   localparam kw_text_type KW_TEXT [KW_COUNT] = '{
      {"RESET",     32'h0},
      {"ALL_COILS"},
      {"TEMP",      40'h0},
      {"BPM",       48'h0},
      {"ALL",       48'h0},
      {"INPUTS",    24'h0}
   };

   localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
      POS_W'(5), POS_W'(9), POS_W'(4), POS_W'(3), POS_W'(3), POS_W'(6)
   };

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_item_type;

   typedef struct packed {
      command_type       command;
      logic [ADDR_W-1:0] address;
      logic              by_timeout;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } stage_rsp_type;

endpackage

### rtl/stcp_if.sv
// ----------------------------------------------------------------------------
// stcp channel interfaces
// Valid/ready channels for received bytes and ticks, decoded commands and
// the idle limit register write.
// ----------------------------------------------------------------------------
interface stcp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;

   modport source (output valid, req_type, rx_byte, input ready);
   modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface stcp_rsp_if;
   logic                              valid;
   logic                              ready;
   stcp_pkg::command_type             command;
   logic [stcp_pkg::ADDR_W-1:0]       address;
   logic                              by_timeout;

   modport source (output valid, command, address, by_timeout, input ready);
   modport sink   (input valid, command, address, by_timeout, output ready);
endinterface

interface stcp_csr_if;
   logic                         valid;
   logic                         ready;
   logic [stcp_pkg::LIMIT_W-1:0] idle_limit;

   modport source (output valid, idle_limit, input ready);
   modport sink   (input valid, idle_limit, output ready);
endinterface

### rtl/stcp_in_stage.sv
// ----------------------------------------------------------------------------
// stcp_in_stage
// Input register: holds one accepted item until the decode step takes it.
// ----------------------------------------------------------------------------
module stcp_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  stcp_pkg::req_item_type   in_item,
   input  logic                     room,
   output stcp_pkg::stage_item_type fire
);

   logic                   valid_ff;
   logic                   valid_in;
   stcp_pkg::req_item_type item_ff;
   logic                   advance;

   assign advance  = valid_ff && room;
   assign in_ready = !valid_ff || advance;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign fire.valid = advance;
   assign fire.item  = item_ff;

endmodule

### rtl/stcp_decoder.sv
// ----------------------------------------------------------------------------
// stcp_decoder
// Frame state and on-the-fly field decode; one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module stcp_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  stcp_pkg::stage_item_type          fire,
   input  logic [stcp_pkg::LIMIT_W-1:0]      idle_limit,
   output stcp_pkg::stage_rsp_type           result
);

   logic                              capturing_ff,   capturing_in;
   logic [stcp_pkg::COUNT_W-1:0]      byte_count_ff,  byte_count_in;
   stcp_pkg::phase_type               phase_ff,       phase_in;
   stcp_pkg::verb_type                verb_ff,        verb_in;
   logic [stcp_pkg::POS_W-1:0]        position_ff,    position_in;
   logic [stcp_pkg::KW_COUNT-1:0]     alive_ff,       alive_in;
   logic [stcp_pkg::ADDR_W-1:0]       accum_ff,       accum_in;
   logic                              ended_ff,       ended_in;
   logic                              bad_ff,         bad_in;
   logic [stcp_pkg::LIMIT_W-1:0]      idle_ff,        idle_in;

   logic                              close;
   logic                              timed_out;
   logic                              frame_ok;
   logic [7:0]                        c;
   logic [stcp_pkg::COUNT_W-1:0]      idx;
   logic [stcp_pkg::ADDR_W+3:0]       acc_ext;
   logic [stcp_pkg::ADDR_W+3:0]       acc_next;
   logic [stcp_pkg::KW_COUNT-1:0]     kw_miss;
   logic [stcp_pkg::KW_COUNT-1:0]     kw_len_miss;
   stcp_pkg::command_type             cmd;

   assign c   = fire.item.rx_byte;
   assign idx = byte_count_ff;

   // accum * 10 + digit, at most 9999
   assign acc_ext  = {4'b0, accum_ff};
   assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {10'b0, c[3:0]};

   always_comb begin
      for (int k = 0; k < stcp_pkg::KW_COUNT; k++) begin
         kw_len_miss[k] = (stcp_pkg::KW_LEN[k] != position_ff);
         if (position_ff >= stcp_pkg::KW_LEN[k]) begin
            kw_miss[k] = 1'b1;
         end else begin
            kw_miss[k] = (stcp_pkg::KW_TEXT[k][position_ff[3:0]] != c);
         end
      end
   end

   always_comb begin
      capturing_in  = capturing_ff;
      byte_count_in = byte_count_ff;
      phase_in      = phase_ff;
      verb_in       = verb_ff;
      position_in   = position_ff;
      alive_in      = alive_ff;
      accum_in      = accum_ff;
      ended_in      = ended_ff;
      bad_in        = bad_ff;
      idle_in       = idle_ff;
      close         = 1'b0;
      timed_out     = 1'b0;

      if (fire.valid) begin
         if (fire.item.req_type == stcp_pkg::REQ_TICK) begin
            if (capturing_ff) begin
               idle_in = idle_ff + stcp_pkg::LIMIT_W'(1);
               if (idle_in >= idle_limit) begin
                  close     = 1'b1;
                  timed_out = 1'b1;
               end
            end
         end else begin
            capturing_in = 1'b1;
            idle_in      = '0;
            if (byte_count_ff <= stcp_pkg::COUNT_W'(stcp_pkg::MAX_FRAME_BYTES)) begin
               byte_count_in = byte_count_ff + stcp_pkg::COUNT_W'(1);
            end
            if (byte_count_in > stcp_pkg::COUNT_W'(stcp_pkg::MAX_FRAME_BYTES)) begin
               bad_in = 1'b1;
            end
            if (c == stcp_pkg::CH_STAR) begin
               close = 1'b1;
            end else if (!bad_in) begin
               if (idx == stcp_pkg::COUNT_W'(0)) begin
                  verb_in = (c == stcp_pkg::CH_S) ? stcp_pkg::VERB_SET :
                            (c == stcp_pkg::CH_G) ? stcp_pkg::VERB_GET :
                                                    stcp_pkg::VERB_NONE;
               end else if (idx == stcp_pkg::COUNT_W'(1)) begin
                  if (c != stcp_pkg::CH_E) verb_in = stcp_pkg::VERB_NONE;
               end else if (idx == stcp_pkg::COUNT_W'(2)) begin
                  if (c != stcp_pkg::CH_T) verb_in = stcp_pkg::VERB_NONE;
               end else if (idx == stcp_pkg::COUNT_W'(3)) begin
                  // separator byte is skipped
                  phase_in    = stcp_pkg::PH_PARAM;
                  position_in = '0;
               end else if (phase_ff == stcp_pkg::PH_PARAM) begin
                  if (c == stcp_pkg::CH_EQUAL) begin
                     alive_in    = alive_ff & ~kw_len_miss;
                     phase_in    = stcp_pkg::PH_ADDR;
                     position_in = '0;
                  end else if (position_ff >=
                               stcp_pkg::POS_W'(stcp_pkg::MAX_PARAM_CHARS)) begin
                     bad_in = 1'b1;
                  end else begin
                     alive_in    = alive_ff & ~kw_miss;
                     position_in = position_ff + stcp_pkg::POS_W'(1);
                  end
               end else if (phase_ff == stcp_pkg::PH_ADDR) begin
                  if (c == stcp_pkg::CH_COLON) begin
                     phase_in    = stcp_pkg::PH_VALUE;
                     position_in = '0;
                  end else if (position_ff >=
                               stcp_pkg::POS_W'(stcp_pkg::MAX_ADDRESS_DIGITS)) begin
                     bad_in = 1'b1;
                  end else begin
                     if (!ended_ff && c >= stcp_pkg::CH_ZERO && c <= stcp_pkg::CH_NINE) begin
                        accum_in = (acc_next > {4'b0, stcp_pkg::ADDRESS_CEIL}) ?
                                   stcp_pkg::ADDRESS_CEIL : acc_next[stcp_pkg::ADDR_W-1:0];
                     end else begin
                        ended_in = 1'b1;
                     end
                     position_in = position_ff + stcp_pkg::POS_W'(1);
                  end
               end
            end
         end
      end

      frame_ok = !bad_in &&
                 (byte_count_in > stcp_pkg::COUNT_W'(stcp_pkg::MIN_FRAME_BYTES)) &&
                 (phase_in == stcp_pkg::PH_VALUE);
      cmd = stcp_pkg::CMD_NONE;
      if (frame_ok && verb_in == stcp_pkg::VERB_SET && !timed_out &&
          alive_in[stcp_pkg::KW_RESET]) begin
         cmd = stcp_pkg::CMD_RESET;
      end else if (frame_ok && verb_in == stcp_pkg::VERB_GET) begin
         if (alive_in[stcp_pkg::KW_COILS])       cmd = stcp_pkg::CMD_COILS;
         else if (alive_in[stcp_pkg::KW_TEMP])   cmd = stcp_pkg::CMD_TEMP;
         else if (alive_in[stcp_pkg::KW_BPM])    cmd = stcp_pkg::CMD_BPM;
         else if (alive_in[stcp_pkg::KW_ALL])    cmd = stcp_pkg::CMD_ALL;
         else if (alive_in[stcp_pkg::KW_INPUTS]) cmd = stcp_pkg::CMD_INPUTS;
      end

      result.valid           = close;
      result.item.command    = cmd;
      result.item.address    = (cmd == stcp_pkg::CMD_NONE || cmd == stcp_pkg::CMD_RESET) ?
                               '0 : accum_in;
      result.item.by_timeout = timed_out;

      if (close) begin
         capturing_in  = 1'b0;
         byte_count_in = '0;
         phase_in      = stcp_pkg::PH_VERB;
         verb_in       = stcp_pkg::VERB_NONE;
         position_in   = '0;
         alive_in      = '1;
         accum_in      = '0;
         ended_in      = 1'b0;
         bad_in        = 1'b0;
         idle_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff  <= 1'b0;
         byte_count_ff <= '0;
         phase_ff      <= stcp_pkg::PH_VERB;
         verb_ff       <= stcp_pkg::VERB_NONE;
         position_ff   <= '0;
         alive_ff      <= '1;
         accum_ff      <= '0;
         ended_ff      <= 1'b0;
         bad_ff        <= 1'b0;
         idle_ff       <= '0;
      end else begin
         capturing_ff  <= capturing_in;
         byte_count_ff <= byte_count_in;
         phase_ff      <= phase_in;
         verb_ff       <= verb_in;
         position_ff   <= position_in;
         alive_ff      <= alive_in;
         accum_ff      <= accum_in;
         ended_ff      <= ended_in;
         bad_ff        <= bad_in;
         idle_ff       <= idle_in;
      end
   end

endmodule

### rtl/stcp_out_stage.sv
// ----------------------------------------------------------------------------
// stcp_out_stage
// Result register: holds a decoded command until the receiver takes it.
// ----------------------------------------------------------------------------
module stcp_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  stcp_pkg::stage_rsp_type result,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output stcp_pkg::rsp_item_type  out_item
);

   logic                   valid_ff;
   logic                   valid_in;
   stcp_pkg::rsp_item_type item_ff;

   assign room     = !valid_ff || out_ready;
   // room is only offered when the held item leaves this cycle or none is held
   assign valid_in = result.valid ? 1'b1 : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         item_ff <= result.item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/serial_text_command_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_text_command_parser_unit
// Text command frame parser for a serial link.
//
// req_if carries one item per handshake: a received byte (req_type 0) or one
// idle tick (req_type 1). A frame opens on its first byte and closes on '*'
// or after idle_limit ticks in a row with no byte; each closed frame gives
// one item on rsp_if with the decoded command, the address field and a flag
// telling whether the frame closed by timeout. Ticks outside a frame and
// bytes that do not close a frame give no result.
// csr_if writes the idle limit; it is always ready. The user must write it
// only while no item is in flight; the block itself does not enforce this.
// An accepted item waits in the input register until the result register has
// room, then the decode step updates the frame state and loads the result
// register, which offers the result. One item per cycle is sustained while
// the result register is free or being emptied.
// A stalled receiver holds the result register; the input register keeps
// taking items while the result register is free or being emptied.
// Reset closes any open frame, drops items in flight and sets the idle limit
// to 20000.
// ----------------------------------------------------------------------------
module serial_text_command_parser_unit (
   input logic              clock,
   input logic              reset,
   stcp_req_if.sink         req_if,
   stcp_rsp_if.source       rsp_if,
   stcp_csr_if.sink         csr_if
);

   logic [stcp_pkg::LIMIT_W-1:0] idle_limit_ff;
   logic [stcp_pkg::LIMIT_W-1:0] idle_limit_in;
   stcp_pkg::req_item_type       req_item;
   stcp_pkg::stage_item_type     fire;
   stcp_pkg::stage_rsp_type      result;
   stcp_pkg::rsp_item_type       rsp_item;
   logic                         room;

   assign csr_if.ready  = 1'b1;
   assign idle_limit_in = csr_if.valid ? csr_if.idle_limit : idle_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= stcp_pkg::IDLE_LIMIT_RESET;
      end else begin
         idle_limit_ff <= idle_limit_in;
      end
   end

   assign req_item.req_type = req_if.req_type;
   assign req_item.rx_byte  = req_if.rx_byte;

   stcp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .in_item  (req_item),
      .room     (room),
      .fire     (fire)
   );

   stcp_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .idle_limit (idle_limit_ff),
      .result     (result)
   );

   stcp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .room      (room),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_item  (rsp_item)
   );

   assign rsp_if.command    = rsp_item.command;
   assign rsp_if.address    = rsp_item.address;
   assign rsp_if.by_timeout = rsp_item.by_timeout;

   // no address without a read command
   a_addr_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid &&
      (rsp_if.command == stcp_pkg::CMD_NONE || rsp_if.command == stcp_pkg::CMD_RESET)
      |-> rsp_if.address == '0)
      else $error("address set without a read command");

   // a reset request needs the closing star
   a_reset_not_timed: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.command == stcp_pkg::CMD_RESET |-> !rsp_if.by_timeout)
      else $error("reset request from a timed out frame");

   a_addr_ceiling: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.address <= stcp_pkg::ADDRESS_CEIL)
      else $error("address above ceiling");

   // a result needs an item taken from the input register in the same cycle
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> fire.valid)
      else $error("result without an item");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result offered right after reset");

endmodule
